@@ rtl/pptq_pkg.sv @@
// Shared types and codes for the preemptive priority task queue.
// No dependencies; used by the top level, the RAM wrapper users and the checker.

package pptq_pkg;

   // field widths
   localparam int unsigned PRIO_W   = 14;
   localparam int unsigned HANDLE_W = 16;
   localparam int unsigned ARG_W    = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned TYPE_W   = 2;
   localparam int unsigned COUNT_W  = 5;

   // stream payload widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 88;

   // reset value of the idle level register
   localparam logic [PRIO_W-1:0] IDLE_LEVEL_RESET = 14'd9999;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_ADD      = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DISPATCH = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_COMPLETE = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NONE       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NEST_FULL  = 3'd5;

   // one waiting task as stored in the queue memory
   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      logic [HANDLE_W-1:0] handle;
      logic [ARG_W-1:0]    arg;
   } entry_type;

endpackage

@@ rtl/preemptive_priority_task_queue_unit.sv @@
// Top level of the preemptive priority task queue: sorted task ring in RAM,
// nesting stack in RAM, sequencer and response register.
// Depends on pptq_pkg and pptq_ram.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------
//  req     | in  | req_tvalid/tready    | tuser kind, tdata priority/handle/arg
//  rsp     | out | rsp_tvalid/tready    | tuser status, tdata task/level/count
//  csr     | in  | csr_valid/csr_ready  | csr_wdata idle level
//
//  An add walks the ring from the tail and moves each waiting task of larger
//  priority up by one place, with one read and one write of the queue RAM
//  per cycle. Dispatch and complete do one RAM read and then one update;
//  other requests go straight to the response.
//  Reset is synchronous; both RAMs need no clearing and are ready at once.
//  A new request beat is taken while the previous response still waits; the
//  sequencer stalls in its final cycle until the response register frees.
//  An idle level write is taken only while the sequencer is idle and holds off
//  a request beat in that cycle.

module preemptive_priority_task_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned NEST_DEPTH  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = {arg[61:30], handle[29:14], priority[13:0]}, zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pptq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // request: tuser = req_type[1:0]
   input  logic [pptq_pkg::TYPE_W-1:0]        req_tuser,
   // response: tdata = {queued_count[80:76], running_level[75:62],
   //   out_priority[61:48], out_argument[47:16], out_handle[15:0]}, zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pptq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // response: tuser = status[2:0]
   output logic [pptq_pkg::STATUS_W-1:0]      rsp_tuser,
   // idle level register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pptq_pkg::PRIO_W-1:0]        csr_wdata
);

   localparam int unsigned QA  = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int unsigned NW  = $clog2(NEST_DEPTH + 1);
   localparam int unsigned EW  = $bits(pptq_pkg::entry_type);
   localparam int unsigned PW  = pptq_pkg::PRIO_W;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_FIN  = 3'd2;
   localparam logic [2:0] S_HEAD = 3'd3;
   localparam logic [2:0] S_POP  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]                           state_ff, state_in;
   logic [QA-1:0]                        head_ff, head_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [QA-1:0]                        pos_ff, pos_in;
   logic [NW-1:0]                        depth_ff, depth_in;
   logic [PW-1:0]                        running_ff, running_in;
   logic [PW-1:0]                        idle_ff, idle_in;
   pptq_pkg::entry_type                  task_ff, task_in;
   pptq_pkg::entry_type                  out_task_ff, out_task_in;
   logic [pptq_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [pptq_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [pptq_pkg::RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   // memory ports
   logic                q_we, q_re;
   logic [QA-1:0]       q_waddr, q_raddr;
   pptq_pkg::entry_type q_wdata, q_rdata;
   logic                s_we, s_re;
   logic [SAW-1:0]      s_waddr, s_raddr;
   logic [PW-1:0]       s_wdata, s_rdata;

   logic                req_beat, csr_beat, rsp_free;
   logic [CW-1:0]       count_m1;
   logic [NW-1:0]       depth_m1;
   logic [QA-1:0]       pos_m1, pos_m2;
   logic [CW+4:0]       count_wide;
   pptq_pkg::entry_type req_task;

   // logical ring position to physical address
   function automatic logic [QA-1:0] phys(input logic [QA-1:0] base,
                                          input logic [QA-1:0] lpos);
      logic [QA:0] sum;
      sum = {1'b0, base} + {1'b0, lpos};
      if (sum >= (QA+1)'(QUEUE_DEPTH)) begin
         sum = sum - (QA+1)'(QUEUE_DEPTH);
      end
      return sum[QA-1:0];
   endfunction

   // idle level write wins the idle cycle over a request beat
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_beat   = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign count_m1   = count_ff - CW'(1);
   assign depth_m1   = depth_ff - NW'(1);
   assign pos_m1     = pos_ff - QA'(1);
   assign pos_m2     = pos_ff - QA'(2);
   assign count_wide = {5'b0, count_ff};

   // unpack request beat
   assign req_task.prio   = req_tdata[13:0];
   assign req_task.handle = req_tdata[29:14];
   assign req_task.arg    = req_tdata[61:30];

   // sequencer and state update
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      depth_in      = depth_ff;
      running_in    = running_ff;
      idle_in       = idle_ff;
      task_in       = task_ff;
      out_task_in   = out_task_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;

      q_we    = 1'b0;
      q_waddr = phys(head_ff, pos_ff);
      q_wdata = task_ff;
      q_re    = 1'b0;
      q_raddr = phys(head_ff, count_m1[QA-1:0]);
      s_we    = 1'b0;
      s_waddr = depth_ff[SAW-1:0];
      s_wdata = running_ff;
      s_re    = 1'b0;
      s_raddr = depth_m1[SAW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               task_in     = req_task;
               out_task_in = '0;
               case (req_tuser)
                  pptq_pkg::REQ_ADD: begin
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        status_in = pptq_pkg::ST_QUEUE_FULL;
                        state_in  = S_DONE;
                     end else if (count_ff == '0) begin
                        pos_in   = '0;
                        state_in = S_FIN;
                     end else begin
                        // start the walk at the tail entry
                        q_re     = 1'b1;
                        pos_in   = count_ff[QA-1:0];
                        state_in = S_INS;
                     end
                  end
                  pptq_pkg::REQ_DISPATCH: begin
                     if (count_ff == '0) begin
                        status_in = pptq_pkg::ST_NONE;
                        state_in  = S_DONE;
                     end else begin
                        q_re     = 1'b1;
                        q_raddr  = head_ff;
                        state_in = S_HEAD;
                     end
                  end
                  pptq_pkg::REQ_COMPLETE: begin
                     if (depth_ff == '0) begin
                        status_in = pptq_pkg::ST_UNDERFLOW;
                        state_in  = S_DONE;
                     end else begin
                        s_re     = 1'b1;
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     status_in = pptq_pkg::ST_NONE;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_INS: begin
            // read data is the entry just below the hole at pos
            if (q_rdata.prio > task_ff.prio) begin
               q_we    = 1'b1;
               q_wdata = q_rdata;
               pos_in  = pos_m1;
               if (pos_m1 == '0) begin
                  state_in = S_FIN;
               end else begin
                  q_re    = 1'b1;
                  q_raddr = phys(head_ff, pos_m2);
               end
            end else begin
               q_we      = 1'b1;
               count_in  = count_ff + CW'(1);
               status_in = pptq_pkg::ST_ADDED;
               state_in  = S_DONE;
            end
         end
         S_FIN: begin
            q_we      = 1'b1;
            count_in  = count_ff + CW'(1);
            status_in = pptq_pkg::ST_ADDED;
            state_in  = S_DONE;
         end
         S_HEAD: begin
            if (q_rdata.prio >= running_ff) begin
               status_in = pptq_pkg::ST_NONE;
            end else if (depth_ff >= NW'(NEST_DEPTH)) begin
               status_in = pptq_pkg::ST_NEST_FULL;
            end else begin
               // pop the head and push the running level
               s_we        = 1'b1;
               depth_in    = depth_ff + NW'(1);
               head_in     = (head_ff == QA'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QA'(1);
               count_in    = count_m1;
               running_in  = q_rdata.prio;
               out_task_in = q_rdata;
               status_in   = pptq_pkg::ST_DISPATCHED;
            end
            state_in = S_DONE;
         end
         S_POP: begin
            depth_in   = depth_m1;
            running_in = s_rdata;
            status_in  = pptq_pkg::ST_NONE;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = {7'b0, count_wide[4:0], running_ff, out_task_ff.prio,
                                out_task_ff.arg, out_task_ff.handle};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // idle level write, only taken while no request is in flight
      if (csr_beat) begin
         idle_in = csr_wdata;
         if (depth_ff == '0) begin
            running_in = csr_wdata;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         depth_ff     <= '0;
         running_ff   <= pptq_pkg::IDLE_LEVEL_RESET;
         idle_ff      <= pptq_pkg::IDLE_LEVEL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         running_ff   <= running_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      task_ff       <= task_in;
      out_task_ff   <= out_task_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // sorted ring of waiting tasks
   pptq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   // saved running levels
   pptq_ram #(
      .WIDTH (PW),
      .DEPTH (NEST_DEPTH)
   ) u_nest_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ rtl/pptq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module pptq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pptq_checker.sv @@
// Port-level checks for the preemptive priority task queue, bound to the top.
// Depends on pptq_pkg.

module pptq_checker #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [pptq_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [pptq_pkg::TYPE_W-1:0]     req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pptq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [pptq_pkg::STATUS_W-1:0]   rsp_tuser,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [pptq_pkg::PRIO_W-1:0]     csr_wdata
);

   // a stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // task fields are zero unless a task was dispatched
   a_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != pptq_pkg::ST_DISPATCHED |-> rsp_tdata[61:0] == '0)
      else $error("task fields set on a non-dispatch response");

   // a dispatched task becomes the running level
   a_disp_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == pptq_pkg::ST_DISPATCHED |-> rsp_tdata[75:62] == rsp_tdata[61:48])
      else $error("running level differs from dispatched priority");

   // reported waiting count never exceeds the queue size, checked for depths up to 31
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (QUEUE_DEPTH > 31) || (rsp_tdata[80:76] <= 5'(QUEUE_DEPTH)))
      else $error("queued count beyond queue depth");

   // the status code is one of the defined ones
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= pptq_pkg::ST_NEST_FULL)
      else $error("undefined response status");

endmodule

bind preemptive_priority_task_queue_unit pptq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pptq_checker (.*);
